// ===== src/u2d_pkg.sv =====
package u2d_pkg;

  // width of one bcd digit
  localparam int unsigned DigitW = 4;
  // result field widths
  localparam int unsigned CharW = 6;
  localparam int unsigned IndexW = 5;
  // result tdata: char_code and digit_index, padded to whole bytes
  localparam int unsigned OutDataW = 16;
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // operations on the bcd digit register
  typedef enum logic [1:0] {
    BcdHold   = 2'd0,
    BcdClear  = 2'd1,
    BcdDabble = 2'd2,
    BcdDigit  = 2'd3
  } bcd_op_e;

  // control word from the sequencer to the digit register
  typedef struct packed {
    bcd_op_e op;
    logic    bit_in;
  } bcd_ctrl_t;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

// ===== src/u2d_bcd_reg.sv =====
module u2d_bcd_reg #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic                         clk_i,
  input  u2d_pkg::bcd_ctrl_t           ctrl_i,
  output logic [u2d_pkg::DigitW-1:0]   top_digit_o
);
  import u2d_pkg::*;

  localparam int unsigned BcdW = MAX_DIGITS * DigitW;

  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] dabbled;

  // add-3 correction on every digit that is five or more
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*DigitW +: DigitW] inside {[4'd5:4'd15]}) begin
        dabbled[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        dabbled[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  // next register value per operation
  always_comb begin
    case (ctrl_i.op)
      BcdHold:   bcd_d = bcd_q;
      BcdClear:  bcd_d = '0;
      BcdDabble: bcd_d = {dabbled[BcdW-2:0], ctrl_i.bit_in};
      BcdDigit:  bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
      default:   bcd_d = bcd_q;
    endcase
  end

  // digit store, payload only
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdW-1 -: DigitW];

endmodule

// ===== src/u64_to_decimal_digits.sv =====
// unsigned binary to decimal ascii digit stream
//
// input channel s_axis_*: one word per value, the value in the low
// VALUE_BITS bits of tdata; higher bits are ignored.
// output channel m_axis_*: one word per decimal digit, most significant
// first, no leading zeros (zero gives a single '0'); tlast marks the final
// digit of each value.
// a value is taken in, converted by bit-serial double dabble over its
// VALUE_BITS bits, stripped of leading zero digits (up to MAX_DIGITS-1),
// then sent one digit per cycle while the receiver does not stall. the
// shift register conversion handles one value at a time; a new value is
// taken once the last digit of the previous one sits in the output register.
// values needing more than MAX_DIGITS digits keep the low MAX_DIGITS digits.
// a stall on the output holds the pending digit and pauses digit emission.
// reset returns the block to idle with no output word pending.
module u64_to_decimal_digits #(
  parameter int unsigned MAX_DIGITS = 20,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [VALUE_BITS-1:0] value, zero padded to whole bytes
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [5:0] char_code, [10:6] digit_index, [15:11] zero
  output logic [u2d_pkg::OutDataW-1:0]         m_axis_tdata_o,
  output logic                                 m_axis_tlast_o
);
  import u2d_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_BITS);
  localparam int unsigned RemW = $clog2(MAX_DIGITS + 1);

  state_e              state_q, state_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [IndexW-1:0]   idx_q, idx_d;
  logic                ovalid_q, ovalid_d;
  logic [CharW-1:0]    ochar_q, ochar_d;
  logic [IndexW-1:0]   oidx_q, oidx_d;
  logic                olast_q, olast_d;

  bcd_ctrl_t           bcd_ctrl;
  logic [DigitW-1:0]   top_digit;
  logic                in_acc;
  logic                out_free;
  logic                emit;

  u2d_bcd_reg #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_bcd (
    .clk_i      (clk_i),
    .ctrl_i     (bcd_ctrl),
    .top_digit_o(top_digit)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign emit     = (state_q == StEmit) && out_free;

  // sequencer: convert, drop leading zeros, emit digits
  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    bcd_ctrl.op     = BcdHold;
    bcd_ctrl.bit_in = val_q[VALUE_BITS-1];
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          val_d       = s_axis_tdata_i[VALUE_BITS-1:0];
          cnt_d       = CntW'(VALUE_BITS - 1);
          bcd_ctrl.op = BcdClear;
          state_d     = StConv;
        end
      end
      StConv: begin
        bcd_ctrl.op = BcdDabble;
        val_d       = {val_q[VALUE_BITS-2:0], 1'b0};
        cnt_d       = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = RemW'(MAX_DIGITS);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_digit == '0 && rem_q > RemW'(1)) begin
          bcd_ctrl.op = BcdDigit;
          rem_d       = rem_q - 1'b1;
        end else begin
          idx_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          bcd_ctrl.op = BcdDigit;
          rem_d       = rem_q - 1'b1;
          idx_d       = idx_q + 1'b1;
          if (rem_q == RemW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    oidx_d   = oidx_q;
    olast_d  = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      ochar_d  = AsciiZero + {{(CharW-DigitW){1'b0}}, top_digit};
      oidx_d   = idx_q;
      olast_d  = (rem_q == RemW'(1));
    end else if (m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload and counters
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    idx_q   <= idx_d;
    ochar_q <= ochar_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(OutDataW-CharW-IndexW){1'b0}}, oidx_q, ochar_q};
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== test/tb_u64_to_decimal_digits.sv =====
module tb_u64_to_decimal_digits;
  timeunit 1ns;
  timeprecision 1ps;

  import u2d_pkg::*;

  localparam int unsigned MaxDigits = 20;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned InDataW = ((ValueBits + 7) / 8) * 8;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandomItems = 320;
  localparam int unsigned NumPhases = 4;

  // one expected digit word
  typedef struct packed {
    logic [CharW-1:0]  char_code;
    logic [IndexW-1:0] digit_index;
    logic              last_digit;
  } digit_word_t;

  // expected digit words, filled on each accepted value, drained on each digit
  class digit_scoreboard;
    digit_word_t digit_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return digit_q.size();
    endfunction

    // decimal digits of an accepted value, most significant first
    function void note_value(logic [InDataW-1:0] raw);
      logic [3:0]          digs[MaxDigits];
      logic [ValueBits-1:0] rest;
      int unsigned         n;
      digit_word_t         w;
      rest = raw[ValueBits-1:0];
      n = 0;
      // low digits first, keeping at most MaxDigits of them
      do begin
        digs[n] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
        n++;
      end while (rest != 0 && n < MaxDigits);
      // drop leading zeros, keep at least one digit
      while (n > 1 && digs[n-1] == 4'd0) n--;
      for (int unsigned k = 0; k < n; k++) begin
        w.char_code   = AsciiZero + CharW'(digs[n-1-k]);
        w.digit_index = IndexW'(k);
        w.last_digit  = (k + 1 == n);
        digit_q.push_back(w);
      end
    endfunction

    // compare one output digit word with the oldest expectation
    function void check_digit(logic [OutDataW-1:0] tdata, logic tlast);
      digit_word_t exp_w;
      logic [CharW-1:0]  got_char;
      logic [IndexW-1:0] got_index;
      logic [OutDataW-CharW-IndexW-1:0] got_pad;
      got_char  = tdata[CharW-1:0];
      got_index = tdata[CharW+IndexW-1:CharW];
      got_pad   = tdata[OutDataW-1:CharW+IndexW];
      if (digit_q.size() == 0) begin
        $error("unexpected digit word: char_code %0d, digit_index %0d, last %0b",
               got_char, got_index, tlast);
        errors++;
        return;
      end
      exp_w = digit_q.pop_front();
      if (got_char !== exp_w.char_code) begin
        $error("char_code mismatch: expected %0d, actual %0d", exp_w.char_code, got_char);
        errors++;
      end
      if (got_index !== exp_w.digit_index) begin
        $error("digit_index mismatch: expected %0d, actual %0d",
               exp_w.digit_index, got_index);
        errors++;
      end
      if (tlast !== exp_w.last_digit) begin
        $error("last_digit mismatch: expected %0b, actual %0b", exp_w.last_digit, tlast);
        errors++;
      end
      if (got_pad !== '0) begin
        $error("tdata padding mismatch: expected 0, actual %0h", got_pad);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  digit_scoreboard digit_sb = new();

  u64_to_decimal_digits #(
    .MAX_DIGITS(MaxDigits),
    .VALUE_BITS(ValueBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_u64_to_decimal_digits failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      digit_sb.check_digit(m_axis_tdata, m_axis_tlast);
    end
  end

  // offer one value word, idling at random first, and wait for acceptance
  task automatic send_value(input logic [InDataW-1:0] v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    digit_sb.note_value(v);
  endtask

  // random value with a spread of digit counts and inner zeros
  function automatic logic [InDataW-1:0] rand_value();
    logic [63:0] v;
    logic [63:0] pow;
    int unsigned k;
    v = {$urandom, $urandom};
    case ($urandom_range(4, 0))
      0: begin
      end
      1: begin
        v = v >> $urandom_range(63, 0);
      end
      2: begin
        // decimal digits built one by one, zeros frequent
        k = $urandom_range(19, 1);
        v = 64'($urandom_range(9, 1));
        for (int unsigned i = 1; i < k; i++) begin
          if ($urandom_range(99, 0) < 40) v = v * 64'd10;
          else v = v * 64'd10 + 64'($urandom_range(9, 0));
        end
      end
      3: begin
        v = 64'($urandom_range(99, 0));
      end
      default: begin
        // around a power of ten
        k = $urandom_range(19, 1);
        pow = 64'd1;
        for (int unsigned i = 0; i < k; i++) pow = pow * 64'd10;
        v = pow + 64'($urandom_range(2, 0)) - 64'd1;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] directed_q[$];
    directed_q = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd101,
      64'd1000000007, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'd1000000000000000000, 64'd1000000000000000001,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'd10000000000000000001, 64'd12345678901234567890,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and digit-count boundaries, no idling
    foreach (directed_q[i]) send_value(directed_q[i]);

    // random phases: none, sender idle, receiver stall, both
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 47;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 47;
        end
        default: begin
          send_idle_pct  <= 24;
          recv_stall_pct <= 24;
        end
      endcase
      for (int unsigned n = 0; n < RandomItems / NumPhases; n++) begin
        // long receiver hold-off while values keep coming
        if (ph == 0 && n == 10) hold_req <= hold_req + 1;
        send_value(rand_value());
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (digit_sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (digit_sb.errors == 0 && digit_sb.pending() == 0) begin
      $display("tb_u64_to_decimal_digits passed");
    end else begin
      $display("tb_u64_to_decimal_digits failed");
    end
    $finish;
  end

endmodule

// ===== u64_to_decimal_digits.f =====
src/u2d_pkg.sv
src/u2d_bcd_reg.sv
src/u64_to_decimal_digits.sv
test/tb_u64_to_decimal_digits.sv
